FILE: rtl/audio_ring_playback_feeder_assert.svh
// Assertion macros shared by the feeder RTL.
// Both sample on clk and are disabled while rst_n is low.
`ifndef AUDIO_RING_PLAYBACK_FEEDER_ASSERT_SVH
`define AUDIO_RING_PLAYBACK_FEEDER_ASSERT_SVH

// Same-cycle implication
`define ARPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ARPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/arpf_pkg.sv
package arpf_pkg;

    // Ring geometry
    localparam int RING_DEPTH          = 2048;
    localparam int PTR_W               = $clog2(RING_DEPTH);
    localparam int HALF_BUFFER_SAMPLES = 64;
    localparam int FRAMES_PER_HALF     = HALF_BUFFER_SAMPLES >> 1;
    localparam int FRM_W               = $clog2(FRAMES_PER_HALF);

    // Field widths
    localparam int SMP_W  = 16;
    localparam int FILL_W = 11;
    localparam int THR_W  = 11;
    localparam int CMP_W  = (PTR_W > THR_W) ? PTR_W : THR_W;

    // Register file
    localparam logic [1:0]       ADDR_START_THR  = 2'd0;
    localparam logic [THR_W-1:0] START_THR_RESET = THR_W'(192);

    // Request kinds
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_REFILL = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // Result kinds
    localparam logic [1:0] RK_STATUS   = 2'd0;
    localparam logic [1:0] RK_FRAME    = 2'd1;
    localparam logic [1:0] RK_UNDERRUN = 2'd2;

    typedef struct packed {
        logic [1:0]              kind;
        logic signed [SMP_W-1:0] sample;
    } arpf_req_t;

    typedef struct packed {
        logic [1:0]              result_kind;
        logic signed [SMP_W-1:0] left;
        logic signed [SMP_W-1:0] right;
        logic                    last;
        logic                    playing;
        logic [FILL_W-1:0]       fill_level;
        logic                    dropped;
    } arpf_res_t;

endpackage

FILE: rtl/audio_ring_playback_feeder.sv
// Channel   Handshake               Payload       Notes
// request   start in / busy out     req           taken when start && !busy
// result    res_valid out           res           one-cycle strobe, no backpressure
// config    psel/penable/pwrite     paddr, pwdata APB, pready tied high, reg 0 at 0x0
//
// A push that starts no playback, or any request that ends in a single result,
// registers its result in the decide state; busy drops with that strobe.
// A refill emits 32 frames, a playback start up to 64, one per cycle after the
// decide and prep states; the single read port of the ring sets the frame rate.
// Reset clears pointers, playback flag and held sample; the ring itself is not
// cleared and needs no sweep. Results cannot be stalled.
module audio_ring_playback_feeder
    import arpf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // request channel
    input  logic             start,
    output logic             busy,
    input  arpf_req_t        req,
    // result channel
    output logic             res_valid,
    output arpf_res_t        res,
    // configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [1:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PREP,
        ST_EMIT
    } state_t;

    localparam logic [PTR_W-1:0] RING_MASK = PTR_W'(RING_DEPTH - 1);
    localparam logic [FRM_W-1:0] FRM_LAST  = FRM_W'(FRAMES_PER_HALF - 1);

    state_t            state_reg, state_next;
    logic [1:0]        kind_reg, kind_next;
    logic [SMP_W-1:0]  sample_reg, sample_next;
    logic [PTR_W-1:0]  write_ptr_reg, write_ptr_next;
    logic [PTR_W-1:0]  read_ptr_reg, read_ptr_next;
    logic              play_reg, play_next;
    logic [SMP_W-1:0]  held_reg, held_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic              drop_reg, drop_next;
    logic              two_half_reg, two_half_next;
    logic              half_reg, half_next;
    logic [FRM_W-1:0]  cnt_reg, cnt_next;
    arpf_res_t         res_reg, res_next;
    logic              res_valid_reg, res_valid_next;
    logic [SMP_W-1:0]  rd_data_reg;

    logic [SMP_W-1:0]  ring_mem [RING_DEPTH];

    logic              wr_en;
    logic [SMP_W-1:0]  wr_data;
    logic [PTR_W-1:0]  fill_cur;
    logic [PTR_W-1:0]  fill_new;
    logic [PTR_W-1:0]  fill_after;
    logic              push_drop;
    logic              emit_status;
    logic [1:0]        status_kind;
    logic              status_drop;

    assign fill_cur = write_ptr_reg - read_ptr_reg;
    // stored sample carries the write pointer's low bit as dither
    assign wr_data  = sample_reg + {{(SMP_W-1){1'b0}}, write_ptr_reg[0]};

    // sequencer and datapath next-state
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        sample_next    = sample_reg;
        write_ptr_next = write_ptr_reg;
        read_ptr_next  = read_ptr_reg;
        play_next      = play_reg;
        held_next      = held_reg;
        thr_next       = thr_reg;
        drop_next      = drop_reg;
        two_half_next  = two_half_reg;
        half_next      = half_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        wr_en          = 1'b0;
        push_drop      = (fill_cur == RING_MASK);
        fill_new       = push_drop ? fill_cur : fill_cur + 1'b1;
        fill_after     = fill_cur;
        emit_status    = 1'b0;
        status_kind    = RK_STATUS;
        status_drop    = 1'b0;

        // register write
        if (psel && penable && pwrite && paddr == ADDR_START_THR)
        begin
            thr_next = pwdata[THR_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next   = req.kind;
                    sample_next = req.sample;
                    state_next  = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                cnt_next  = '0;
                half_next = 1'b0;
                case (kind_reg)
                    KIND_PUSH:
                    begin
                        if (!push_drop)
                        begin
                            wr_en          = 1'b1;
                            write_ptr_next = write_ptr_reg + 1'b1;
                        end
                        if (!play_reg && CMP_W'(fill_new) >= CMP_W'(thr_reg))
                        begin
                            play_next     = 1'b1;
                            drop_next     = push_drop;
                            two_half_next = 1'b1;
                            state_next    = ST_PREP;
                        end
                        else
                        begin
                            emit_status = 1'b1;
                            status_drop = push_drop;
                        end
                    end
                    KIND_REFILL:
                    begin
                        if (play_reg && fill_cur != '0)
                        begin
                            drop_next     = 1'b0;
                            two_half_next = 1'b0;
                            state_next    = ST_PREP;
                        end
                        else
                        begin
                            emit_status = 1'b1;
                            if (play_reg)
                            begin
                                play_next   = 1'b0;
                                status_kind = RK_UNDERRUN;
                            end
                        end
                    end
                    KIND_END:
                    begin
                        if (!play_reg)
                        begin
                            play_next = 1'b1;
                        end
                        if (!play_reg && fill_cur != '0)
                        begin
                            drop_next     = 1'b0;
                            two_half_next = 1'b1;
                            state_next    = ST_PREP;
                        end
                        else
                        begin
                            emit_status = 1'b1;
                        end
                    end
                    default:
                    begin
                        emit_status = 1'b1;
                    end
                endcase

                // single result for this request
                if (emit_status)
                begin
                    res_valid_next       = 1'b1;
                    res_next.result_kind = status_kind;
                    res_next.left        = '0;
                    res_next.right       = '0;
                    res_next.last        = 1'b1;
                    res_next.playing     = play_next;
                    res_next.fill_level  = FILL_W'(write_ptr_next - read_ptr_reg);
                    res_next.dropped     = status_drop;
                    state_next           = ST_IDLE;
                end
            end

            // lets a write from this request reach the read register
            ST_PREP:
            begin
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                // read while samples remain, else repeat the held one
                if (fill_cur != '0)
                begin
                    held_next     = rd_data_reg;
                    read_ptr_next = read_ptr_reg + 1'b1;
                end
                fill_after           = write_ptr_reg - read_ptr_next;
                res_valid_next       = 1'b1;
                res_next.result_kind = RK_FRAME;
                res_next.left        = held_next;
                res_next.right       = held_next;
                res_next.last        = 1'b0;
                res_next.playing     = play_reg;
                res_next.fill_level  = FILL_W'(fill_after);
                res_next.dropped     = drop_reg;
                cnt_next             = cnt_reg + 1'b1;
                if (cnt_reg == FRM_LAST)
                begin
                    cnt_next = '0;
                    // second half only if samples are left
                    if (two_half_reg && !half_reg && fill_after != '0)
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        res_next.last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= '0;
            sample_reg    <= '0;
            write_ptr_reg <= '0;
            read_ptr_reg  <= '0;
            play_reg      <= 1'b0;
            held_reg      <= '0;
            thr_reg       <= START_THR_RESET;
            drop_reg      <= 1'b0;
            two_half_reg  <= 1'b0;
            half_reg      <= 1'b0;
            cnt_reg       <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            sample_reg    <= sample_next;
            write_ptr_reg <= write_ptr_next;
            read_ptr_reg  <= read_ptr_next;
            play_reg      <= play_next;
            held_reg      <= held_next;
            thr_reg       <= thr_next;
            drop_reg      <= drop_next;
            two_half_reg  <= two_half_next;
            half_reg      <= half_next;
            cnt_reg       <= cnt_next;
            res_reg       <= res_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ring storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[write_ptr_reg] <= wr_data;
        end
        rd_data_reg <= ring_mem[read_ptr_next];
    end

    assign busy      = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_START_THR) ? 32'(thr_reg) : '0;

    // checks
`include "audio_ring_playback_feeder_assert.svh"
    `ARPF_ASSERT_NOW(a_last_frees, res_valid && res.last, !busy, "final result while busy")
    `ARPF_ASSERT_NOW(a_more_busy, res_valid && !res.last, busy, "non-final result while idle")
    `ARPF_ASSERT_NOW(a_underrun_stops, res_valid && (res.result_kind == RK_UNDERRUN), !res.playing && res.last, "underrun did not stop playback")
    `ARPF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request not in work")

endmodule

FILE: bench/arpf_checker.sv
// Scoreboard for the playback feeder: tracks threshold writes, predicts the
// result stream of every accepted request and compares the strobed results.
module arpf_checker
    import arpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  arpf_req_t   req,
    input  logic        res_valid,
    input  arpf_res_t   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        run_done,
    output int          outstanding,
    output int          fail_count
);

    localparam logic [PTR_W-1:0] RING_FULL = PTR_W'(RING_DEPTH - 1);

    // Shadow copy of the feeder state
    logic [SMP_W-1:0] ring_m [RING_DEPTH];
    logic [PTR_W-1:0] wr_ptr_m;
    logic [PTR_W-1:0] rd_ptr_m;
    logic             playing_m;
    logic [SMP_W-1:0] held_m;
    logic [THR_W-1:0] thr_m;

    arpf_res_t due_results [$];

    int  frames_seen;
    int  underruns_seen;
    int  drops_seen;
    bit  reported;

    function automatic logic [PTR_W-1:0] ring_count();
        return wr_ptr_m - rd_ptr_m;
    endfunction

    function automatic void queue_result(logic [1:0] rk, logic [SMP_W-1:0] smp,
                                         logic drop);
        arpf_res_t r;
        r.result_kind = rk;
        r.left        = smp;
        r.right       = smp;
        r.last        = 1'b0;
        r.playing     = playing_m;
        r.fill_level  = FILL_W'(ring_count());
        r.dropped     = drop;
        due_results.push_back(r);
    endfunction

    // One half-buffer; short rings are padded with the held sample
    function automatic bit play_half(logic drop);
        int unsigned avail;
        int unsigned take;
        int          i;
        avail = ring_count();
        if (avail == 0)
            return 1'b0;
        take = (avail < FRAMES_PER_HALF) ? avail : FRAMES_PER_HALF;
        for (i = 0; i < FRAMES_PER_HALF; i++)
        begin
            if (i < take)
            begin
                held_m   = ring_m[rd_ptr_m];
                rd_ptr_m = rd_ptr_m + 1'b1;
            end
            queue_result(RK_FRAME, held_m, drop);
        end
        return 1'b1;
    endfunction

    function automatic void begin_playback(logic drop);
        playing_m = 1'b1;
        void'(play_half(drop));
        void'(play_half(drop));
    endfunction

    function automatic void predict_feeder(arpf_req_t rq);
        logic drop;
        int   queued_before;
        drop          = 1'b0;
        queued_before = due_results.size();
        case (rq.kind)
            KIND_PUSH:
            begin
                if (ring_count() == RING_FULL)
                    drop = 1'b1;
                else
                begin
                    // dither: low bit of the write pointer, 16-bit wrap
                    ring_m[wr_ptr_m] = rq.sample + SMP_W'(wr_ptr_m[0]);
                    wr_ptr_m         = wr_ptr_m + 1'b1;
                end
                if (!playing_m && ring_count() >= thr_m)
                    begin_playback(drop);
            end
            KIND_REFILL:
            begin
                if (playing_m && !play_half(1'b0))
                begin
                    playing_m = 1'b0;
                    queue_result(RK_UNDERRUN, '0, 1'b0);
                end
            end
            KIND_END:
            begin
                if (!playing_m)
                    begin_playback(1'b0);
            end
            default: ;
        endcase
        if (due_results.size() == queued_before)
            queue_result(RK_STATUS, '0, drop);
        due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        arpf_res_t want;
        if (!rst_n)
        begin
            wr_ptr_m    = '0;
            rd_ptr_m    = '0;
            playing_m   = 1'b0;
            held_m      = '0;
            thr_m       = START_THR_RESET;
            due_results.delete();
            fail_count  = 0;
            outstanding = 0;
            frames_seen    = 0;
            underruns_seen = 0;
            drops_seen     = 0;
            reported       = 1'b0;
        end
        else
        begin
            // results first: a request taken at this edge cannot answer yet
            if (res_valid)
            begin
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: kind=%0d left=%0d fill=%0d",
                                 res.result_kind, res.left, res.fill_level);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (res.result_kind !== want.result_kind || res.left !== want.left ||
                        res.right !== want.right || res.last !== want.last ||
                        res.playing !== want.playing ||
                        res.fill_level !== want.fill_level ||
                        res.dropped !== want.dropped)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: exp kind=%0d l=%0d r=%0d last=%b play=%b",
                                      " fill=%0d drop=%b | got kind=%0d l=%0d r=%0d",
                                      " last=%b play=%b fill=%0d drop=%b"},
                                     want.result_kind, want.left, want.right, want.last,
                                     want.playing, want.fill_level, want.dropped,
                                     res.result_kind, res.left, res.right, res.last,
                                     res.playing, res.fill_level, res.dropped);
                    end
                    if (want.result_kind == RK_FRAME)
                        frames_seen++;
                    if (want.result_kind == RK_UNDERRUN)
                        underruns_seen++;
                    if (want.dropped && want.last)
                        drops_seen++;
                end
            end

            // threshold register write
            if (psel && penable && pwrite && pready && paddr == ADDR_START_THR)
                thr_m = pwdata[THR_W-1:0];

            if (start && !busy)
                predict_feeder(req);

            // leftovers count once the stimulus has finished
            if (run_done && !reported)
            begin
                reported = 1'b1;
                if (due_results.size() != 0)
                begin
                    $display("%0d expected results never arrived", due_results.size());
                    fail_count += due_results.size();
                end
                $display("checked %0d frames, %0d underrun stops, %0d dropped pushes",
                         frames_seen, underruns_seen, drops_seen);
            end
            outstanding = due_results.size();
        end
    end

endmodule

FILE: bench/tb_top.sv
module tb_top;
    import arpf_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    arpf_req_t   req;
    logic        res_valid;
    arpf_res_t   res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        run_done;
    int          outstanding;
    int          fail_count;

    int cycle_count;
    bit gaps_on;
    int n_push;
    int n_refill;
    int n_end;
    int n_unused;
    int n_thr;

    audio_ring_playback_feeder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .res_valid (res_valid),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    arpf_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .res_valid   (res_valid),
        .res         (res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .run_done    (run_done),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** audio_ring_playback_feeder: FAILED **");
            $finish;
        end
    end

    // Issue one request; start stays high into the next request when no gap falls
    task automatic send_req(input logic [1:0] k, input logic [SMP_W-1:0] s);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= '{kind: k, sample: s};
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        case (k)
            KIND_PUSH:   n_push++;
            KIND_REFILL: n_refill++;
            KIND_END:    n_end++;
            default:     n_unused++;
        endcase
    endtask

    // Block idle: no request in flight, every expected result seen
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_thr(input int unsigned v);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_START_THR;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_thr++;
    endtask

    function automatic logic [SMP_W-1:0] pick_sample();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        return SMP_W'($urandom);
    endfunction

    task automatic run_random(input int n);
        int         i;
        int         pick;
        logic [1:0] k;
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                k = KIND_PUSH;
            else if (pick < 80)
                k = KIND_REFILL;
            else if (pick < 93)
                k = KIND_END;
            else
                k = KIND_UNUSED;
            send_req(k, pick_sample());
        end
    endtask

    initial
    begin
        int i;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        req      <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        run_done <= 1'b0;
        cycle_count = 0;
        gaps_on     = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stopped and empty at the reset threshold
        send_req(KIND_REFILL, 16'h0000);
        send_req(KIND_UNUSED, 16'hFFFF);
        send_req(KIND_END, 16'h0000);
        send_req(KIND_END, 16'h5555);
        send_req(KIND_REFILL, 16'hAAAA);

        // small threshold; odd write slots exercise the dither wrap
        write_thr(4);
        send_req(KIND_PUSH, 16'h7FFF);
        send_req(KIND_PUSH, 16'h7FFF);
        send_req(KIND_PUSH, 16'h8000);
        send_req(KIND_PUSH, 16'hFFFF);
        send_req(KIND_PUSH, 16'h1234);
        send_req(KIND_REFILL, 16'h0000);
        send_req(KIND_REFILL, 16'h0000);

        // zero threshold: any push while stopped starts playback
        write_thr(0);
        send_req(KIND_PUSH, 16'h0001);
        send_req(KIND_REFILL, 16'h0000);

        write_thr(1);
        send_req(KIND_END, 16'h0000);
        send_req(KIND_REFILL, 16'h0000);

        // top threshold: pushes stay stopped, stream end plays a padded
        // second half, then the ring underruns
        write_thr(2047);
        for (i = 0; i < FRAMES_PER_HALF + 8; i++)
            send_req(KIND_PUSH, pick_sample());
        send_req(KIND_END, 16'h0000);
        send_req(KIND_REFILL, 16'h0000);
        send_req(KIND_REFILL, 16'h0000);

        // random traffic across several thresholds, last stretch without gaps
        write_thr(1);
        run_random(25);
        write_thr(START_THR_RESET);
        run_random(25);
        write_thr($urandom_range(2, 300));
        run_random(25);
        write_thr(2047);
        gaps_on = 1'b0;
        run_random(25);

        wait_drained();
        repeat (8) @(posedge clk);
        run_done <= 1'b1;
        repeat (2) @(posedge clk);
        $display("sent %0d pushes, %0d refills, %0d stream ends, %0d unused-kind requests",
                 n_push, n_refill, n_end, n_unused);
        $display("over %0d threshold settings", n_thr);
        if (fail_count == 0)
            $display("** audio_ring_playback_feeder: PASSED **");
        else
            $display("** audio_ring_playback_feeder: FAILED **");
        $finish;
    end

endmodule
